// ===== rtl/core/efcd_pkg.sv =====
// ----------------------------------------------------------------------------
// efcd_pkg
// Shared types and constants of the event corner detector: field widths,
// controller states and the two circle offset tables.
// ----------------------------------------------------------------------------
package efcd_pkg;

  localparam int unsigned XW = 11;
  localparam int unsigned YW = 10;
  localparam int unsigned TW = 32;

  localparam int unsigned BORDER = 4;
  localparam int unsigned C3_N = 16;
  localparam int unsigned C4_N = 20;
  localparam int unsigned C3_LO = 3;
  localparam int unsigned C3_HI = 6;
  localparam int unsigned C4_LO = 4;
  localparam int unsigned C4_HI = 8;

  localparam logic [2:0] REG_DETECT_ENABLE = 3'd0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_WRITE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } efcd_state_e;

  typedef logic signed [3:0] ofs_t;

  localparam ofs_t C3_DX [C3_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t C3_DY [C3_N] = '{
    4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};
  localparam ofs_t C4_DX [C4_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t C4_DY [C4_N] = '{
    4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4};

endpackage

// ===== rtl/core/efcd_if.sv =====
// ----------------------------------------------------------------------------
// efcd_in_if / efcd_out_if
// Valid/ready channels for event beats in and classification beats out.
// ----------------------------------------------------------------------------
interface efcd_in_if;
  logic                     valid;
  logic                     ready;
  logic [efcd_pkg::XW-1:0]  x;
  logic [efcd_pkg::YW-1:0]  y;
  logic [efcd_pkg::TW-1:0]  t;
  modport source (output valid, x, y, t, input ready);
  modport sink (input valid, x, y, t, output ready);
endinterface

interface efcd_out_if;
  logic                     valid;
  logic                     ready;
  logic [efcd_pkg::XW-1:0]  out_x;
  logic [efcd_pkg::YW-1:0]  out_y;
  logic                     is_corner;
  logic                     near_border;
  modport source (output valid, out_x, out_y, is_corner, near_border, input ready);
  modport sink (input valid, out_x, out_y, is_corner, near_border, output ready);
endinterface

// ===== rtl/core/efcd_ram.sv =====
// ----------------------------------------------------------------------------
// efcd_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module efcd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/event_fast_corner_detector_core.sv =====
// Flow: border, off-sensor or disabled events go from the input beat through
// ST_BASE and ST_WRITE to the result; others then read the C3 ring and scan its
// arcs and, if the small circle passes, read the C4 ring and scan its arcs.
// Throughput: one event at a time; the surface RAM port and the one-candidate-
// per-cycle arc scan set the figure. After reset the surface is zeroed by a
// sweep over all SENSOR_WIDTH*SENSOR_HEIGHT addresses, during which no event is taken.
// ----------------------------------------------------------------------------
// event_fast_corner_detector_core
// Event FAST corner detector on a RAM-held surface of latest timestamps.
// ----------------------------------------------------------------------------
module event_fast_corner_detector_core #(
  parameter int unsigned SENSOR_WIDTH   = 1280,
  parameter int unsigned SENSOR_HEIGHT  = 720,
  parameter int unsigned TIMESTAMP_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  efcd_in_if.sink     in_i,
  efcd_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import efcd_pkg::*;

  localparam int unsigned DEPTH = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TSW   = TIMESTAMP_BITS;

  efcd_state_e state_q, state_d;

  logic           en_q;
  logic [XW-1:0]  x_q, x_d;
  logic [YW-1:0]  y_q, y_d;
  logic [TSW-1:0] t_q, t_d;
  logic [AW-1:0]  base_q, base_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           border_q, border_d;
  logic           n4_q, n4_d;
  logic [4:0]     cnt_q, cnt_d;
  logic           rdv_q, rdv_d;
  logic [4:0]     i_q, i_d;
  logic [3:0]     s_q, s_d;
  logic [TSW-1:0] m_q, m_d;
  logic [TSW-1:0] v_q [C4_N];
  logic           corner_q, corner_d;

  logic           ovld_q, ovld_d;
  logic [XW-1:0]  ox_q, ox_d;
  logic [YW-1:0]  oy_q, oy_d;
  logic           oc_q, oc_d;
  logic           ob_q, ob_d;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [TSW-1:0] wdata, rdata;
  logic           shift_en;
  logic [TSW-1:0] shift_src;

  logic [4:0]     n_w;
  logic [3:0]     lo_w, hi_w;
  logic [TSW-1:0] mn3, m_init, m_now, v_prev, v_end, v_nxt;
  logic           outside_bad, pass;
  int             ofs;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DETECT_ENABLE) ? {31'd0, en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_DETECT_ENABLE) begin
      en_q <= pwdata[0];
    end
  end

  efcd_ram #(.WIDTH(TSW), .DEPTH(DEPTH)) u_surface (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // ring geometry
  assign n_w  = n4_q ? 5'(C4_N) : 5'(C3_N);
  assign lo_w = n4_q ? 4'(C4_LO) : 4'(C3_LO);
  assign hi_w = n4_q ? 4'(C4_HI) : 4'(C3_HI);

  always_comb begin
    if (n4_q) begin
      ofs = int'(C4_DY[cnt_q]) * int'(SENSOR_WIDTH) + int'(C4_DX[cnt_q]);
    end else begin
      ofs = int'(C3_DY[cnt_q[3:0]]) * int'(SENSOR_WIDTH) + int'(C3_DX[cnt_q[3:0]]);
    end
    raddr = AW'(32'(base_q) + 32'(ofs));
  end

  // arc test for start at v[0], length s
  always_comb begin
    mn3    = (v_q[1] < v_q[0]) ? v_q[1] : v_q[0];
    mn3    = (v_q[2] < mn3) ? v_q[2] : mn3;
    m_init = (n4_q && v_q[3] < mn3) ? v_q[3] : mn3;
    v_prev = v_q[5'(s_q - 4'd1)];
    v_nxt  = v_q[5'(s_q)];
    v_end  = n4_q ? v_q[C4_N-1] : v_q[C3_N-1];
    if (s_q == lo_w) begin
      m_now = m_init;
    end else begin
      m_now = (v_prev < m_q) ? v_prev : m_q;
    end
    outside_bad = 1'b0;
    for (int j = 0; j < C4_N; j++) begin
      if (5'(j) >= 5'(s_q) && 5'(j) < n_w && v_q[j] >= m_now) begin
        outside_bad = 1'b1;
      end
    end
    pass = !(v_q[0] < v_end) && !(v_prev < v_nxt) && !outside_bad;
  end

  // value ring: rotate during scan, shift in during read
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int k = 0; k < C4_N; k++) begin
        if (5'(k) == n_w - 5'd1 || k == C4_N - 1) begin
          v_q[k] <= shift_src;
        end else begin
          v_q[k] <= v_q[k+1];
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    t_d       = t_q;
    base_d    = base_q;
    clr_d     = clr_q;
    border_d  = border_q;
    n4_d      = n4_q;
    cnt_d     = cnt_q;
    rdv_d     = 1'b0;
    i_d       = i_q;
    s_d       = s_q;
    m_d       = m_q;
    corner_d  = corner_q;
    ovld_d    = ovld_q && !out_o.ready;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oc_d      = oc_q;
    ob_d      = ob_q;
    we        = 1'b0;
    waddr     = base_q;
    wdata     = t_q;
    shift_en  = 1'b0;
    shift_src = v_q[0];
    in_i.ready = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          x_d     = in_i.x;
          y_d     = in_i.y;
          t_d     = TSW'(in_i.t);
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        base_d   = AW'(32'(y_q) * 32'(SENSOR_WIDTH) + 32'(x_q));
        border_d = 32'(x_q) < BORDER || 32'(x_q) >= SENSOR_WIDTH - BORDER ||
                   32'(y_q) < BORDER || 32'(y_q) >= SENSOR_HEIGHT - BORDER;
        state_d  = ST_WRITE;
      end
      ST_WRITE: begin
        we       = 32'(x_q) < SENSOR_WIDTH && 32'(y_q) < SENSOR_HEIGHT;
        corner_d = 1'b0;
        n4_d     = 1'b0;
        cnt_d    = '0;
        if (en_q && !border_q) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        shift_en  = rdv_q;
        shift_src = rdata;
        if (cnt_q == n_w) begin
          i_d     = '0;
          s_d     = lo_w;
          state_d = ST_SCAN;
        end else begin
          rdv_d = 1'b1;
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_SCAN: begin
        m_d = m_now;
        if (pass) begin
          if (n4_q) begin
            corner_d = 1'b1;
            state_d  = ST_DONE;
          end else begin
            n4_d    = 1'b1;
            cnt_d   = '0;
            state_d = ST_READ;
          end
        end else if (s_q == hi_w) begin
          shift_en = 1'b1;
          s_d      = lo_w;
          i_d      = i_q + 5'd1;
          if (i_q == n_w - 5'd1) begin
            state_d = ST_DONE;
          end
        end else begin
          s_d = s_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          ox_d    = x_q;
          oy_d    = y_q;
          oc_d    = corner_q;
          ob_d    = border_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rdv_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rdv_q   <= rdv_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    t_q      <= t_d;
    base_q   <= base_d;
    border_q <= border_d;
    n4_q     <= n4_d;
    cnt_q    <= cnt_d;
    i_q      <= i_d;
    s_q      <= s_d;
    m_q      <= m_d;
    corner_q <= corner_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oc_q     <= oc_d;
    ob_q     <= ob_d;
  end

  assign out_o.valid       = ovld_q;
  assign out_o.out_x       = ox_q;
  assign out_o.out_y       = oy_q;
  assign out_o.is_corner   = oc_q;
  assign out_o.near_border = ob_q;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for event_fast_corner_detector_core. Event beats come
// from a queue that the stimulus block fills. A predictor holds its own
// timestamp surface and classifies each accepted beat. Result beats are
// checked in order against those predictions. Most random traffic is built
// as ring patterns around a centre pixel, so that the arc tests on both
// circles are exercised. Both channels idle in random bursts until the last part.
// ----------------------------------------------------------------------------
module tb;
  import efcd_pkg::*;

  localparam int unsigned SW = 1280;
  localparam int unsigned SH = 720;
  localparam int unsigned SETTLE = 250;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [TW-1:0] t;
  } event_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          corner;
    logic          border;
  } class_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  efcd_in_if  ev_if ();
  efcd_out_if cls_if ();

  event_fast_corner_detector_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (cls_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  event_t      pending_events [$];
  class_t      expected_cls [$];
  logic [TW-1:0] surface_ts [int];
  logic        detect_en;
  int          mismatches;
  longint unsigned cycles;
  bit          in_taken, out_taken;
  bit          hold_off, no_idle;
  int          in_gap, out_gap;
  logic        drv_valid, drv_ready;
  event_t      cur_ev;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [TW-1:0] surf_rd(int px, int py);
    int idx;
    idx = py * SW + px;
    return surface_ts.exists(idx) ? surface_ts[idx] : '0;
  endfunction

  function automatic bit arc_present(input logic [TW-1:0] v [20], int n, int lo, int hi);
    logic [TW-1:0] m;
    bit ok;
    for (int i = 0; i < n; i++) begin
      for (int s = lo; s <= hi; s++) begin
        if (v[i] < v[(i + n - 1) % n]) continue;
        if (v[(i + s - 1) % n] < v[(i + s) % n]) continue;
        m = v[i];
        for (int j = 1; j < s; j++)
          if (v[(i + j) % n] < m) m = v[(i + j) % n];
        ok = 1'b1;
        for (int j = s; j < n; j++)
          if (v[(i + j) % n] >= m) ok = 1'b0;
        if (ok) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic class_t predict_event(event_t e);
    class_t c;
    logic [TW-1:0] v [20];
    bit on_s;
    on_s = (e.x < SW) && (e.y < SH);
    if (on_s) surface_ts[int'(e.y) * SW + int'(e.x)] = e.t;
    c.x = e.x;
    c.y = e.y;
    c.corner = 1'b0;
    c.border = !on_s || e.x < BORDER || e.x >= SW - BORDER ||
               e.y < BORDER || e.y >= SH - BORDER;
    if (detect_en && !c.border) begin
      for (int k = 0; k < 20; k++) v[k] = '0;
      for (int k = 0; k < C3_N; k++)
        v[k] = surf_rd(int'(e.x) + C3_DX[k], int'(e.y) + C3_DY[k]);
      if (arc_present(v, C3_N, C3_LO, C3_HI)) begin
        for (int k = 0; k < C4_N; k++)
          v[k] = surf_rd(int'(e.x) + C4_DX[k], int'(e.y) + C4_DY[k]);
        c.corner = arc_present(v, C4_N, C4_LO, C4_HI);
      end
    end
    return c;
  endfunction

  // accept, predict, check
  always @(posedge clk_i) begin
    class_t exp_c;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_fast_corner_detector_core regression: fail");
      $finish;
    end
    in_taken = ev_if.valid && ev_if.ready;
    out_taken = cls_if.valid && cls_if.ready;
    if (in_taken) begin
      expected_cls.insert(expected_cls.size(), predict_event({ev_if.x, ev_if.y, ev_if.t}));
    end
    if (out_taken) begin
      if (expected_cls.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        exp_c = expected_cls.pop_front();
        if (cls_if.out_x !== exp_c.x) begin
          $error("out_x exp %0d got %0d", exp_c.x, cls_if.out_x); mismatches++;
        end
        if (cls_if.out_y !== exp_c.y) begin
          $error("out_y exp %0d got %0d", exp_c.y, cls_if.out_y); mismatches++;
        end
        if (cls_if.is_corner !== exp_c.corner) begin
          $error("is_corner exp %0d got %0d", exp_c.corner, cls_if.is_corner);
          mismatches++;
        end
        if (cls_if.near_border !== exp_c.border) begin
          $error("near_border exp %0d got %0d", exp_c.border, cls_if.near_border);
          mismatches++;
        end
      end
    end
  end

  // event driver
  always @(negedge clk_i) begin
    if (ev_if.valid && !in_taken) begin
      drv_valid = 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      drv_valid = 1'b0;
    end else if (rst_ni && !hold_off && pending_events.size() > 0) begin
      if (!no_idle && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        drv_valid = 1'b0;
      end else begin
        cur_ev = pending_events.pop_front();
        ev_if.x <= cur_ev.x;
        ev_if.y <= cur_ev.y;
        ev_if.t <= cur_ev.t;
        drv_valid = 1'b1;
      end
    end else begin
      drv_valid = 1'b0;
    end
    ev_if.valid <= drv_valid;
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      drv_ready = 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      drv_ready = 1'b0;
    end else begin
      drv_ready = 1'b1;
    end
    cls_if.ready <= drv_ready;
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_DETECT_ENABLE) detect_en = data[0];
  endtask

  task automatic drain();
    wait (pending_events.size() == 0 && !ev_if.valid && expected_cls.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_ev(int x, int y, logic [TW-1:0] t);
    event_t e;
    e.x = XW'(x); e.y = YW'(y); e.t = t;
    pending_events.insert(pending_events.size(), e);
  endtask

  // ring pattern around a centre: a newer arc on each circle, then the centre
  task automatic ring_pattern(inout logic [TW-1:0] tb_base, inout int n_ev);
    int cx, cy, a, s, off;
    bit broken;
    logic [TW-1:0] tv;
    cx = $urandom_range(4, 40);
    cy = $urandom_range(4, 30);
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom_range(4, SW - 5);
      cy = $urandom_range(4, SH - 5);
    end
    broken = ($urandom_range(0, 4) == 0);
    a = $urandom_range(0, C3_N - 1);
    s = $urandom_range(2, 7);
    for (int k = 0; k < C3_N; k++) begin
      off = (k - a + C3_N) % C3_N;
      tv = tb_base + (off < s ? 100 : 0) + $urandom_range(0, 60);
      if (broken && $urandom_range(0, 7) == 0) tv = tb_base + 200;
      push_ev(cx + C3_DX[k], cy + C3_DY[k], tv);
    end
    a = $urandom_range(0, C4_N - 1);
    s = $urandom_range(3, 9);
    for (int k = 0; k < C4_N; k++) begin
      off = (k - a + C4_N) % C4_N;
      tv = tb_base + (off < s ? 100 : 0) + $urandom_range(0, 60);
      if (broken && $urandom_range(0, 7) == 0) tv = tb_base + 200;
      push_ev(cx + C4_DX[k], cy + C4_DY[k], tv);
    end
    push_ev(cx, cy, tb_base + 300);
    tb_base += 400;
    n_ev += C3_N + C4_N + 1;
  endtask

  task automatic random_part(int n_target, inout logic [TW-1:0] tb_base);
    int n_ev;
    n_ev = 0;
    while (n_ev < n_target) begin
      if ($urandom_range(0, 9) < 7) begin
        ring_pattern(tb_base, n_ev);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          push_ev($urandom_range(0, 2047), $urandom_range(0, 1023), $urandom());
          n_ev++;
        end
      end
    end
  endtask

  initial begin
    logic [TW-1:0] tb_base;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ev_if.valid = 1'b0; ev_if.x = '0; ev_if.y = '0; ev_if.t = '0;
    cls_if.ready = 1'b0;
    detect_en = 1'b1;
    mismatches = 0; cycles = 0; in_gap = 0; out_gap = 0;
    hold_off = 1'b0; no_idle = 1'b0; in_taken = 1'b0; out_taken = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    reg_write(REG_DETECT_ENABLE, 32'd1);

    // directed: corners of the sensor, border edges, off-sensor, timestamp extremes
    push_ev(0, 0, 32'd0);
    push_ev(2047, 1023, 32'hFFFF_FFFF);
    push_ev(SW - 1, SH - 1, 32'hFFFF_FFFF);
    push_ev(3, 10, 32'd5);
    push_ev(4, 4, 32'd7);
    push_ev(SW - 5, SH - 5, 32'h8000_0000);
    push_ev(SW - 4, 100, 32'd9);
    push_ev(100, 3, 32'd9);
    push_ev(100, SH - 4, 32'd9);
    push_ev(SW, 50, 32'd11);
    push_ev(50, SH, 32'd11);
    push_ev(1024, 512, 32'h5555_5555);
    push_ev(1023, 511, 32'hAAAA_AAAA);
    push_ev(10, 10, 32'hFFFF_FFFF);
    push_ev(10, 10, 32'd0);
    drain();

    tb_base = $urandom_range(1000, 32'h7000_0000);
    random_part(500, tb_base);
    drain();

    reg_write(REG_DETECT_ENABLE, 32'hFFFF_FFFE);
    random_part(250, tb_base);
    drain();

    reg_write(REG_DETECT_ENABLE, 32'hFFFF_FFFF);
    random_part(400, tb_base);
    wait (pending_events.size() < 200);
    hold_off = 1'b1;
    wait (expected_cls.size() == 0 && !ev_if.valid);
    repeat (SETTLE) @(posedge clk_i);
    hold_off = 1'b0;
    wait (pending_events.size() == 0);
    no_idle = 1'b1;
    tb_base = 32'hFFFF_F000;
    random_part(250, tb_base);
    drain();

    if (mismatches == 0 && expected_cls.size() == 0) begin
      $display("event_fast_corner_detector_core regression: pass");
    end else begin
      $display("event_fast_corner_detector_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/efcd_pkg.sv
rtl/core/efcd_if.sv
rtl/core/efcd_ram.sv
rtl/core/event_fast_corner_detector_core.sv
dv/tb.sv
